/* rtl/core/gcd_lcm_unit_defines.svh */
// Assertion macros shared by the gcd and lcm unit.
`ifndef GCD_LCM_UNIT_DEFINES_SVH
`define GCD_LCM_UNIT_DEFINES_SVH

// Clocked assertion that is switched off while reset is high.
`define GLU_ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define GLU_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

/* rtl/core/glu_pkg.sv */
// Package with the payload types and constants of the gcd and lcm unit.
package glu_pkg;

   // Field widths of the request and response beats.
   localparam int GLU_OPERAND_WIDTH = 31;
   localparam int GLU_LCM_WIDTH     = 62;

   // Default datapath width handed to the top level.
   localparam int GLU_DATA_WIDTH = 31;

   typedef struct packed {
      logic [GLU_OPERAND_WIDTH-1:0] operand_a;
      logic [GLU_OPERAND_WIDTH-1:0] operand_b;
   } glu_req_type;

   typedef struct packed {
      logic [GLU_OPERAND_WIDTH-1:0] gcd_value;
      logic [GLU_LCM_WIDTH-1:0]     lcm_value;
      logic                         lcm_undefined;
   } glu_rsp_type;

endpackage

/* rtl/core/glu_div.sv */
// Restoring divider that produces one quotient bit per cycle.
module glu_div #(
   parameter int W = glu_pkg::GLU_DATA_WIDTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quot,
   output logic [W-1:0] rem
);
   import glu_pkg::*;

   localparam int CW = $clog2(W);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  quot_ff, quot_in;
   logic [W-1:0]  dsr_ff, dsr_in;

   logic [W:0]    shifted;
   logic [W:0]    diff;

   // Trial subtraction of the divisor from the shifted partial remainder.
   assign shifted = {rem_ff, quot_ff[W-1]};
   assign diff    = shifted - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quot_in = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         // Keep the difference only when it did not go negative.
         rem_in  = diff[W] ? shifted[W-1:0] : diff[W-1:0];
         quot_in = {quot_ff[W-2:0], ~diff[W]};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CW'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      dsr_ff  <= dsr_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule

/* rtl/core/gcd_lcm_unit.sv */
// Each Euclid remainder step and the final quotient run in the shared one-bit divider.
// The lcm multiply is shift-and-add; a zero operand skips quotient and multiply.
// One item is in work at a time; the next beat is taken once the result is registered.
// Reset (synchronous, active high) returns the sequencer to idle and empties the output.
`include "gcd_lcm_unit_defines.svh"

module gcd_lcm_unit #(
   parameter int DATA_WIDTH = glu_pkg::GLU_DATA_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  glu_pkg::glu_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output glu_pkg::glu_rsp_type rsp_payload
);
   import glu_pkg::*;

   // Operand bits above the smaller of the datapath width and the field width are ignored.
   localparam int OW = (DATA_WIDTH < GLU_OPERAND_WIDTH) ? DATA_WIDTH : GLU_OPERAND_WIDTH;
   localparam int LW = 2 * OW;
   localparam int CW = $clog2(OW);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_GCD_KICK = 3'd1;
   localparam logic [2:0] S_GCD_WAIT = 3'd2;
   localparam logic [2:0] S_QUO_KICK = 3'd3;
   localparam logic [2:0] S_QUO_WAIT = 3'd4;
   localparam logic [2:0] S_MUL      = 3'd5;
   localparam logic [2:0] S_FINISH   = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [OW-1:0] a0_ff, a0_in;
   logic [OW-1:0] b0_ff, b0_in;
   logic [OW-1:0] a_ff, a_in;
   logic [OW-1:0] b_ff, b_in;
   logic [LW-1:0] mcand_ff, mcand_in;
   logic [OW-1:0] mplier_ff, mplier_in;
   logic [LW-1:0] prod_ff, prod_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   glu_rsp_type   rsp_ff, rsp_in;

   logic          div_start;
   logic [OW-1:0] div_dividend;
   logic [OW-1:0] div_divisor;
   logic          div_done;
   logic [OW-1:0] div_quot;
   logic [OW-1:0] div_rem;
   logic          any_zero;
   logic          out_free;

   assign any_zero = (a0_ff == '0) || (b0_ff == '0);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // The divider serves both the remainder loop and the final quotient.
   assign div_start    = ((state_ff == S_GCD_KICK) && (b_ff != '0)) || (state_ff == S_QUO_KICK);
   assign div_dividend = (state_ff == S_QUO_KICK) ? a0_ff : a_ff;
   assign div_divisor  = (state_ff == S_QUO_KICK) ? a_ff : b_ff;

   glu_div #(
      .W(OW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   // Sequencer for Euclid's loop, the quotient and the shift-and-add multiply.
   always_comb begin
      state_in     = state_ff;
      a0_in        = a0_ff;
      b0_in        = b0_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      prod_in      = prod_ff;
      cnt_in       = cnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               a0_in    = req_payload.operand_a[OW-1:0];
               b0_in    = req_payload.operand_b[OW-1:0];
               a_in     = req_payload.operand_a[OW-1:0];
               b_in     = req_payload.operand_b[OW-1:0];
               state_in = S_GCD_KICK;
            end
         end
         S_GCD_KICK: begin
            if (b_ff == '0) begin
               state_in = any_zero ? S_FINISH : S_QUO_KICK;
            end else begin
               state_in = S_GCD_WAIT;
            end
         end
         S_GCD_WAIT: begin
            if (div_done) begin
               a_in     = b_ff;
               b_in     = div_rem;
               state_in = S_GCD_KICK;
            end
         end
         S_QUO_KICK: begin
            state_in = S_QUO_WAIT;
         end
         S_QUO_WAIT: begin
            if (div_done) begin
               mplier_in = div_quot;
               mcand_in  = LW'(b0_ff);
               prod_in   = '0;
               cnt_in    = '0;
               state_in  = S_MUL;
            end
         end
         S_MUL: begin
            // One multiplier bit per cycle, least significant first.
            if (mplier_ff[0]) begin
               prod_in = prod_ff + mcand_ff;
            end
            mcand_in  = {mcand_ff[LW-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[OW-1:1]};
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == CW'(OW - 1)) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            // Load the output register when it is empty or its beat is being taken.
            if (out_free) begin
               rsp_in.gcd_value     = GLU_OPERAND_WIDTH'(a_ff);
               rsp_in.lcm_value     = any_zero ? '0 : GLU_LCM_WIDTH'(prod_ff);
               rsp_in.lcm_undefined = (a0_ff == '0) && (b0_ff == '0);
               rsp_valid_in         = 1'b1;
               state_in             = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a0_ff     <= a0_in;
      b0_ff     <= b0_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      prod_ff   <= prod_in;
      cnt_ff    <= cnt_in;
      rsp_ff    <= rsp_in;
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // The divider only finishes while the sequencer waits for it.
   `GLU_ASSERT_CLK(a_div_done_waited,
      div_done |-> ((state_ff == S_GCD_WAIT) || (state_ff == S_QUO_WAIT)),
      "divider finished outside a wait state")

   // An undefined lcm comes with a zero gcd and a zero lcm.
   `GLU_ASSERT_CLK(a_undef_zero,
      (rsp_valid_ff && rsp_ff.lcm_undefined) |->
         ((rsp_ff.gcd_value == '0) && (rsp_ff.lcm_value == '0)),
      "undefined lcm with nonzero result fields")

   // A finished item waits while the output register is occupied and stalled.
   `GLU_ASSERT_CLK(a_finish_holds,
      ((state_ff == S_FINISH) && rsp_valid_ff && rsp_stall) |=> (state_ff == S_FINISH),
      "result overwrote a stalled response beat")

   // An accepted request, taken only in idle, starts the remainder loop.
   `GLU_ASSERT_CLK(a_accept_from_idle,
      (req_valid && !req_stall) |=> (state_ff == S_GCD_KICK),
      "accepted request did not start the remainder loop")

endmodule

/* tb/sv/gcd_lcm_checker.sv */
// Checker for the gcd and lcm unit: predicts each response beat and compares it.
module gcd_lcm_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  glu_pkg::glu_req_type req_payload,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  glu_pkg::glu_rsp_type rsp_payload,
   output int                   error_count,
   output int                   pending_count
);
   import glu_pkg::*;

   // Responses owed by the block, oldest first.
   glu_rsp_type owed_results[$];

   // Euclid's remainder loop for the gcd, then (a / gcd) * b at full width for the lcm.
   function automatic glu_rsp_type gcd_lcm_of(logic [GLU_OPERAND_WIDTH-1:0] a,
                                              logic [GLU_OPERAND_WIDTH-1:0] b);
      logic [63:0] x;
      logic [63:0] y;
      logic [63:0] rem;
      logic [63:0] prod;
      glu_rsp_type res;
      x = 64'(a);
      y = 64'(b);
      while (y != 64'd0) begin
         rem = x % y;
         x   = y;
         y   = rem;
      end
      res.gcd_value     = x[GLU_OPERAND_WIDTH-1:0];
      res.lcm_value     = '0;
      res.lcm_undefined = 1'b0;
      if (a == '0 && b == '0) begin
         // Both zero: gcd is zero and the lcm has no meaning.
         res.lcm_undefined = 1'b1;
      end else if (a != '0 && b != '0) begin
         prod          = (64'(a) / x) * 64'(b);
         res.lcm_value = prod[GLU_LCM_WIDTH-1:0];
      end
      return res;
   endfunction

   // Queue a prediction for every accepted request beat and check every accepted response beat.
   always @(posedge clock) begin
      glu_rsp_type want;
      if (reset) begin
         owed_results.delete();
         error_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (owed_results.size() == 0) begin
               $error("response beat with no request outstanding: gcd %0d lcm %0d undef %0b",
                      rsp_payload.gcd_value, rsp_payload.lcm_value, rsp_payload.lcm_undefined);
               error_count++;
            end else begin
               want = owed_results.pop_front();
               if (rsp_payload.gcd_value !== want.gcd_value) begin
                  $error("gcd_value mismatch: expected %0d, actual %0d",
                         want.gcd_value, rsp_payload.gcd_value);
                  error_count++;
               end
               if (rsp_payload.lcm_value !== want.lcm_value) begin
                  $error("lcm_value mismatch: expected %0d, actual %0d",
                         want.lcm_value, rsp_payload.lcm_value);
                  error_count++;
               end
               if (rsp_payload.lcm_undefined !== want.lcm_undefined) begin
                  $error("lcm_undefined mismatch: expected %0b, actual %0b",
                         want.lcm_undefined, rsp_payload.lcm_undefined);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            owed_results.insert(owed_results.size(),
                                gcd_lcm_of(req_payload.operand_a, req_payload.operand_b));
         end
      end
      pending_count = owed_results.size();
   end

endmodule

/* tb/sv/tb.sv */
// Top of the gcd and lcm unit testbench: clock, reset, stimulus, and the verdict.
module tb;
   import glu_pkg::*;

   localparam logic [GLU_OPERAND_WIDTH-1:0] OPERAND_MAX = '1;
   localparam int RANDOM_PER_PHASE = 250;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   glu_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   glu_rsp_type rsp_payload;

   int error_count;
   int pending_count;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;

   // Fibonacci numbers: consecutive pairs make Euclid's loop run longest.
   logic [GLU_OPERAND_WIDTH-1:0] fib[47];

   gcd_lcm_unit #(
      .DATA_WIDTH(GLU_DATA_WIDTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   gcd_lcm_checker checker_inst (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload),
      .error_count  (error_count),
      .pending_count(pending_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // The receiver stalls at random with the current phase's percentage.
   always @(posedge clock) begin
      rsp_stall <= (receiver_stall_pct != 0) && ($urandom_range(99) < receiver_stall_pct);
   end

   // Drive one request beat, with random idle cycles ahead of it, and wait until it is taken.
   task automatic send_pair(logic [GLU_OPERAND_WIDTH-1:0] a, logic [GLU_OPERAND_WIDTH-1:0] b);
      if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid   <= 1'b1;
      req_payload <= '{operand_a: a, operand_b: b};
      do @(posedge clock); while (req_stall);
   endtask

   // One random operand: zero, or drawn from full-width, small and width-limited values.
   function automatic logic [GLU_OPERAND_WIDTH-1:0] random_operand();
      int sel;
      int w;
      sel = $urandom_range(19);
      if (sel == 0) begin
         return '0;
      end else if (sel < 9) begin
         return GLU_OPERAND_WIDTH'($urandom);
      end else if (sel < 13) begin
         return GLU_OPERAND_WIDTH'($urandom_range(1, 1000));
      end else begin
         w = $urandom_range(1, GLU_OPERAND_WIDTH);
         return GLU_OPERAND_WIDTH'($urandom) & ((OPERAND_MAX >> (GLU_OPERAND_WIDTH - w)));
      end
   endfunction

   // Random pair: independent operands, a shared factor, or neighboring Fibonacci numbers.
   task automatic send_random_pair();
      int kind;
      int idx;
      logic [GLU_OPERAND_WIDTH-1:0] factor;
      kind = $urandom_range(9);
      if (kind < 6) begin
         send_pair(random_operand(), random_operand());
      end else if (kind < 9) begin
         factor = GLU_OPERAND_WIDTH'($urandom_range(1, 65535));
         send_pair(factor * GLU_OPERAND_WIDTH'($urandom_range(1, 32767)),
                   factor * GLU_OPERAND_WIDTH'($urandom_range(1, 32767)));
      end else begin
         idx = $urandom_range(1, 45);
         if ($urandom_range(1) == 1) begin
            send_pair(fib[idx + 1], fib[idx]);
         end else begin
            send_pair(fib[idx], fib[idx + 1]);
         end
      end
   endtask

   // Stimulus: directed corner cases, then random phases with different sender idling and receiver stalling.
   initial begin
      fib[0] = '0;
      fib[1] = GLU_OPERAND_WIDTH'(1);
      for (int i = 2; i < 47; i++) begin
         fib[i] = fib[i - 1] + fib[i - 2];
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero operands, extremes, equal values, multiples, bit patterns and Fibonacci neighbors.
      send_pair('0, '0);
      send_pair('0, 31'd12);
      send_pair(31'd12, '0);
      send_pair('0, OPERAND_MAX);
      send_pair(OPERAND_MAX, '0);
      send_pair(31'd1, 31'd1);
      send_pair(OPERAND_MAX, OPERAND_MAX);
      send_pair(OPERAND_MAX, 31'd1);
      send_pair(31'd1, OPERAND_MAX);
      send_pair(OPERAND_MAX, OPERAND_MAX - 31'd1);
      send_pair(31'h4000_0000, 31'h2000_0000);
      send_pair(31'h5555_5555, 31'h2AAA_AAAA);
      send_pair(31'h2AAA_AAAA, 31'h5555_5555);
      send_pair(31'd12, 31'd18);
      send_pair(31'd7, 31'd21);
      send_pair(31'd21, 31'd7);
      send_pair(fib[46], fib[45]);
      send_pair(fib[45], fib[46]);
      send_pair(31'd2147483629, OPERAND_MAX);
      send_pair(31'd65536, 31'd65535);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct    = 78;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 78;
            end
            default: begin
               sender_idle_pct    = 34;
               receiver_stall_pct = 34;
            end
         endcase
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            send_random_pair();
         end
      end
      req_valid <= 1'b0;

      // Let the checker record the last request beat, then drain the remaining responses.
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (error_count == 0 && pending_count == 0) begin
         $display("PASS gcd_lcm_unit");
      end else begin
         $display("FAIL gcd_lcm_unit");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #80_000_000;
      $display("FAIL gcd_lcm_unit");
      $finish;
   end

endmodule
